### rtl/scsp_pkg.sv
// Shared types and constants of the S-curve speed profile planner.
package scsp_pkg;

  // Width of a speed value in 1/256 rpm, and of a ramp length or position in ticks.
  localparam int unsigned SPD_W = 16;

  // One smoothstep ramp: start speed, end speed, length in ticks, position in ticks.
  typedef struct packed {
    logic [SPD_W-1:0] origin;
    logic [SPD_W-1:0] target;
    logic [SPD_W-1:0] length;
    logic [SPD_W-1:0] pos;
  } curve_t;

endpackage

### rtl/scsp_curve_eval.sv
// Shared-arithmetic evaluation of one smoothstep ramp point: serial divider and one multiplier.
module scsp_curve_eval (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  scsp_pkg::curve_t            curve_i,
  output logic                        done_o,
  output logic [scsp_pkg::SPD_W-1:0]  value_o
);
  import scsp_pkg::*;

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_DIV  = 3'd1;
  localparam logic [2:0] E_MUL1 = 3'd2;
  localparam logic [2:0] E_MUL2 = 3'd3;
  localparam logic [2:0] E_MUL3 = 3'd4;
  localparam logic [2:0] E_SUM  = 3'd5;

  localparam int unsigned DIV_STEPS = 16;
  localparam logic [17:0] KNEE = 18'd196608;  // 3.0 in Q16

  logic [2:0]       state_q, state_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [SPD_W-1:0] rem_q, rem_d;
  logic [SPD_W-1:0] quo_q, quo_d;
  logic [SPD_W-1:0] len_q, len_d;
  logic [SPD_W-1:0] t2_q, t2_d;
  logic [16:0]      s_q, s_d;
  logic [SPD_W-1:0] step_q, step_d;
  logic [SPD_W-1:0] mag_q, mag_d;
  logic [SPD_W-1:0] origin_q, origin_d;
  logic             up_q, up_d;
  logic             done_q, done_d;
  logic [SPD_W-1:0] value_q, value_d;

  logic [16:0] r2;
  logic [16:0] diff;
  logic        ge;
  logic [17:0] knee_term;
  logic [16:0] mul_a;
  logic [17:0] mul_b;
  logic [34:0] prod;
  logic [31:0] rounded;

  // Restoring division step: the quotient stays below one because pos < length.
  assign r2        = {rem_q, 1'b0};
  assign diff      = r2 - {1'b0, len_q};
  assign ge        = (r2 >= {1'b0, len_q});
  assign knee_term = KNEE - {1'b0, quo_q, 1'b0};

  always_comb begin
    unique case (state_q)
      E_MUL1: begin
        mul_a = {1'b0, quo_q};
        mul_b = {2'b00, quo_q};
      end
      E_MUL2: begin
        mul_a = {1'b0, t2_q};
        mul_b = knee_term;
      end
      E_MUL3: begin
        mul_a = s_q;
        mul_b = {2'b00, mag_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = {18'd0, mul_a} * {17'd0, mul_b};
  assign rounded = prod[31:0] + 32'd32768;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    len_d    = len_q;
    t2_d     = t2_q;
    s_d      = s_q;
    step_d   = step_q;
    mag_d    = mag_q;
    origin_d = origin_q;
    up_d     = up_q;
    done_d   = 1'b0;
    value_d  = value_q;
    unique case (state_q)
      E_IDLE: begin
        if (start_i) begin
          if (curve_i.length == '0 || curve_i.pos >= curve_i.length) begin
            value_d = curve_i.target;
            done_d  = 1'b1;
          end else begin
            rem_d    = curve_i.pos;
            quo_d    = '0;
            cnt_d    = '0;
            len_d    = curve_i.length;
            origin_d = curve_i.origin;
            up_d     = (curve_i.target >= curve_i.origin);
            mag_d    = (curve_i.target >= curve_i.origin) ?
                       (curve_i.target - curve_i.origin) :
                       (curve_i.origin - curve_i.target);
            state_d  = E_DIV;
          end
        end
      end
      E_DIV: begin
        rem_d = ge ? diff[SPD_W-1:0] : r2[SPD_W-1:0];
        quo_d = {quo_q[SPD_W-2:0], ge};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(DIV_STEPS - 1)) begin
          state_d = E_MUL1;
        end
      end
      E_MUL1: begin
        t2_d    = prod[31:16];
        state_d = E_MUL2;
      end
      E_MUL2: begin
        s_d     = prod[32:16];
        state_d = E_MUL3;
      end
      E_MUL3: begin
        step_d  = rounded[31:16];
        state_d = E_SUM;
      end
      E_SUM: begin
        value_d = up_q ? (origin_q + step_q) : (origin_q - step_q);
        done_d  = 1'b1;
        state_d = E_IDLE;
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    len_q    <= len_d;
    t2_q     <= t2_d;
    s_q      <= s_d;
    step_q   <= step_d;
    mag_q    <= mag_d;
    origin_q <= origin_d;
    up_q     <= up_d;
    value_q  <= value_d;
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

### rtl/s_curve_speed_profile_planner.sv
// Top level of the S-curve speed profile planner: phase sequencer, segment walk and result register.
//
// Usage. Each input item on the s_axis channel is one control event: tuser carries the action
// (tick, start key, exit), tdata carries yaw, the finish detector flag and the offset magnitude.
// Every accepted item yields exactly one result item on the m_axis channel with the speed
// command, phase, segment index, damping level, tracking and integral-clear flags, the motor
// stop pulse and the latched finish time.
// The cfg channel writes the six segment registers, the finish yaw threshold and the stop ramp
// length; it is always ready and should only be used while no item is in flight.
// Sequencing. Start, exit, unused and ignored items go from the accept straight to the push
// state, which loads the output register once it is free. Each ramp point costs one pass of
// the shared curve unit: the serial divider, the multiplier for t squared, the smoothstep and
// the scaled step, a final add and the done flag, or a direct answer with the target when the
// ramp has ended or has zero length. A finish-phase tick advances the ramp and needs one pass.
// A run tick walks the segments one step at a time, then needs one pass, or two passes when it
// enters a new segment. One item is processed at a time; s_axis_tready is high only while the
// sequencer is idle, so a new item is taken only after the last result is in the output register.
// Reset puts the block in the idle phase with the default table and a zero speed command.
// When the receiver stalls, the finished result waits in the output register; the next item
// is still accepted and processed, and its result waits until the register is free.
module s_curve_speed_profile_planner (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // yaw [15:0], finish_seen [16], offset_magnitude [28:17]
  input  logic [1:0]  s_axis_tuser,   // action [1:0]
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // speed_command [15:0], phase [17:16],
                                      // segment_index [20:18], damping_level [22:21],
                                      // run_tracking [23], clear_integral [24],
                                      // stop_motors [25], finish_time [57:26]
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  import scsp_pkg::*;

  localparam int unsigned NUM_SEGS = 6;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_RUN    = 2'd1;
  localparam logic [1:0] PH_FINISH = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_EXIT  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [2:0] REG_FINISH_MIN_YAW  = 3'd6;
  localparam logic [2:0] REG_STOP_RAMP_TICKS = 3'd7;

  localparam logic [1:0] DAMP_LOW  = 2'd0;
  localparam logic [1:0] DAMP_MID  = 2'd1;
  localparam logic [1:0] DAMP_HIGH = 2'd2;
  localparam logic [1:0] DAMP_KEEP = 2'd3;

  localparam logic [11:0] OFF_HIGH   = 12'd120;
  localparam logic [11:0] OFF_MID    = 12'd60;
  localparam logic [15:0] STOP_SPEED = 16'd384;  // 1.5 rpm
  localparam logic [2:0]  HOLD_TICKS = 3'd5;

  localparam logic [47:0] SEG_RESET [NUM_SEGS] = '{
    48'd1090519190, 48'd2148574167040, 48'd4295772602488,
    48'd6443256250368, 48'd9020521840760, 48'd12026998947840
  };
  localparam logic [15:0] FMIN_RESET  = 16'd3200;
  localparam logic [15:0] SRAMP_RESET = 16'd250;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_WALK    = 3'd1;
  localparam logic [2:0] ST_OLDWAIT = 3'd2;
  localparam logic [2:0] ST_ADV     = 3'd3;
  localparam logic [2:0] ST_NEWGO   = 3'd4;
  localparam logic [2:0] ST_NEWWAIT = 3'd5;
  localparam logic [2:0] ST_PUSH    = 3'd6;

  // Configuration registers.
  logic [47:0] seg_q [NUM_SEGS];
  logic [15:0] fmin_q;
  logic [15:0] sramp_q;

  // Sequencer and profile state.
  logic [2:0]  state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  seg_ptr_q, seg_ptr_d;
  curve_t      curve_q, curve_d;
  logic [2:0]  hold_q, hold_d;
  logic [11:0] last_off_q, last_off_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [31:0] latched_q, latched_d;
  logic [15:0] speed_q, speed_d;

  // Captured item and per-item results.
  logic [15:0] yaw_q, yaw_d;
  logic        fin_q, fin_d;
  logic [11:0] off_q, off_d;
  logic [1:0]  damp_q, damp_d;
  logic        track_q, track_d;
  logic        clr_q, clr_d;
  logic        stopm_q, stopm_d;

  // Segment walk.
  logic [2:0]  idx_q, idx_d;
  logic [2:0]  walk_i_q, walk_i_d;
  logic [15:0] nxt_spd_q, nxt_spd_d;
  logic [15:0] nxt_ramp_q, nxt_ramp_d;
  logic [47:0] walk_seg;
  logic [2:0]  idx_start;

  // Result register.
  logic        m_valid_q, m_valid_d;
  logic [63:0] out_q, out_d;
  logic        load_out;

  logic        eval_start;
  logic        eval_done;
  logic [15:0] eval_value;
  logic [31:0] elapsed_inc;
  logic [1:0]  damp_now;

  scsp_curve_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eval_start),
    .curve_i (curve_q),
    .done_o  (eval_done),
    .value_o (eval_value)
  );

  // The walk reads one table entry per cycle; positions past the table read as zero.
  always_comb begin
    unique case (walk_i_q)
      3'd0:    walk_seg = seg_q[0];
      3'd1:    walk_seg = seg_q[1];
      3'd2:    walk_seg = seg_q[2];
      3'd3:    walk_seg = seg_q[3];
      3'd4:    walk_seg = seg_q[4];
      3'd5:    walk_seg = seg_q[5];
      default: walk_seg = '0;
    endcase
  end

  assign idx_start   = (seg_ptr_q > 3'(NUM_SEGS - 1)) ? 3'(NUM_SEGS - 1) : seg_ptr_q;
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;

  always_comb begin
    priority if (off_q > OFF_HIGH) begin
      damp_now = DAMP_HIGH;
    end else if (off_q > OFF_MID) begin
      damp_now = DAMP_MID;
    end else begin
      damp_now = DAMP_LOW;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    seg_ptr_d  = seg_ptr_q;
    curve_d    = curve_q;
    hold_d     = hold_q;
    last_off_d = last_off_q;
    elapsed_d  = elapsed_q;
    latched_d  = latched_q;
    speed_d    = speed_q;
    yaw_d      = yaw_q;
    fin_d      = fin_q;
    off_d      = off_q;
    damp_d     = damp_q;
    track_d    = track_q;
    clr_d      = clr_q;
    stopm_d    = stopm_q;
    idx_d      = idx_q;
    walk_i_d   = walk_i_q;
    nxt_spd_d  = nxt_spd_q;
    nxt_ramp_d = nxt_ramp_q;
    eval_start = 1'b0;
    load_out   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          yaw_d   = s_axis_tdata[15:0];
          fin_d   = s_axis_tdata[16];
          off_d   = s_axis_tdata[28:17];
          damp_d  = DAMP_KEEP;
          track_d = 1'b0;
          clr_d   = 1'b0;
          stopm_d = 1'b0;
          state_d = ST_PUSH;
          unique case (s_axis_tuser)
            ACT_START: begin
              // A start key outside idle is ignored.
              if (phase_q == PH_IDLE) begin
                phase_d   = PH_RUN;
                elapsed_d = '0;
                seg_ptr_d = '0;
                curve_d   = '{origin: '0, target: seg_q[0][31:16],
                              length: seg_q[0][15:0], pos: '0};
                speed_d   = '0;
              end
            end
            ACT_EXIT: begin
              phase_d = PH_IDLE;
              speed_d = '0;
              stopm_d = 1'b1;
            end
            ACT_TICK: begin
              if (phase_q == PH_RUN) begin
                idx_d    = idx_start;
                walk_i_d = idx_start + 3'd1;
                state_d  = ST_WALK;
              end else if (phase_q == PH_FINISH) begin
                state_d = ST_ADV;
              end
            end
            ACT_NONE: begin
              // Unused action: the result shows the held state.
            end
            default: begin
            end
          endcase
        end
      end

      ST_WALK: begin
        // Move forward while the yaw has reached the next breakpoint.
        if (walk_i_q < 3'(NUM_SEGS) && yaw_q >= walk_seg[47:32]) begin
          idx_d      = walk_i_q;
          nxt_spd_d  = walk_seg[31:16];
          nxt_ramp_d = walk_seg[15:0];
          walk_i_d   = walk_i_q + 3'd1;
        end else if (idx_q != seg_ptr_q) begin
          // New segment: the ramp restarts from the current ramp value.
          eval_start = 1'b1;
          state_d    = ST_OLDWAIT;
        end else begin
          state_d = ST_ADV;
        end
      end

      ST_OLDWAIT: begin
        if (eval_done) begin
          curve_d   = '{origin: eval_value, target: nxt_spd_q, length: nxt_ramp_q, pos: '0};
          seg_ptr_d = idx_q;
          state_d   = ST_ADV;
        end
      end

      ST_ADV: begin
        if (curve_q.length != '0 && curve_q.pos < curve_q.length) begin
          curve_d.pos = curve_q.pos + 16'd1;
        end
        state_d = ST_NEWGO;
      end

      ST_NEWGO: begin
        eval_start = 1'b1;
        state_d    = ST_NEWWAIT;
      end

      ST_NEWWAIT: begin
        if (eval_done) begin
          speed_d = eval_value;
          damp_d  = damp_now;
          // Tracking stays off while the hold counter runs down.
          if (hold_q == '0) begin
            track_d = 1'b1;
          end else begin
            hold_d = hold_q - 3'd1;
          end
          if (phase_q == PH_RUN) begin
            elapsed_d  = elapsed_inc;
            clr_d      = (last_off_q > OFF_MID) && (off_q <= OFF_MID);
            last_off_d = off_q;
            if (yaw_q > fmin_q && fin_q) begin
              phase_d   = PH_FINISH;
              latched_d = elapsed_inc;
              hold_d    = HOLD_TICKS;
              curve_d   = '{origin: eval_value, target: '0, length: sramp_q, pos: '0};
            end
          end else if (eval_value < STOP_SPEED) begin
            phase_d = PH_STOP;
            speed_d = '0;
            stopm_d = 1'b1;
          end
          state_d = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_valid_d = load_out | (m_valid_q & ~m_axis_tready);
  assign out_d     = load_out ?
                     {6'd0, latched_q, stopm_q, clr_q, track_q, damp_q, seg_ptr_q,
                      phase_q, speed_q} : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_IDLE;
      seg_ptr_q  <= '0;
      curve_q    <= '{origin: '0, target: SEG_RESET[0][31:16],
                      length: SEG_RESET[0][15:0], pos: '0};
      hold_q     <= '0;
      last_off_q <= '0;
      elapsed_q  <= '0;
      latched_q  <= '0;
      speed_q    <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      seg_ptr_q  <= seg_ptr_d;
      curve_q    <= curve_d;
      hold_q     <= hold_d;
      last_off_q <= last_off_d;
      elapsed_q  <= elapsed_d;
      latched_q  <= latched_d;
      speed_q    <= speed_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    yaw_q      <= yaw_d;
    fin_q      <= fin_d;
    off_q      <= off_d;
    damp_q     <= damp_d;
    track_q    <= track_d;
    clr_q      <= clr_d;
    stopm_q    <= stopm_d;
    idx_q      <= idx_d;
    walk_i_q   <= walk_i_d;
    nxt_spd_q  <= nxt_spd_d;
    nxt_ramp_q <= nxt_ramp_d;
    out_q      <= out_d;
  end

  // Configuration registers take a write in any cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SEGS; i++) begin
        seg_q[i] <= SEG_RESET[i];
      end
      fmin_q  <= FMIN_RESET;
      sramp_q <= SRAMP_RESET;
    end else if (cfg_valid_i) begin
      priority if (cfg_index_i < 3'(NUM_SEGS)) begin
        seg_q[cfg_index_i] <= cfg_data_i;
      end else if (cfg_index_i == REG_FINISH_MIN_YAW) begin
        fmin_q <= cfg_data_i[15:0];
      end else if (cfg_index_i == REG_STOP_RAMP_TICKS) begin
        sramp_q <= cfg_data_i[15:0];
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  // The curve unit only answers while the sequencer waits for it.
  a_eval_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_done |-> (state_q == ST_OLDWAIT || state_q == ST_NEWWAIT))
    else $error("curve unit finished outside a wait state");

  // A motor stop pulse goes out only with the idle or stopped phase.
  a_stop_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_q[25]) |-> (out_q[17:16] == PH_IDLE || out_q[17:16] == PH_STOP))
    else $error("stop pulse with a running phase");

  // The reported segment stays inside the table.
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (out_q[20:18] < 3'(NUM_SEGS)))
    else $error("segment index out of range");

  // Tracking is only enabled on a tick that also chose a damping level.
  a_track_damp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_q[23]) |-> (out_q[22:21] != DAMP_KEEP))
    else $error("tracking enabled without a damping choice");

endmodule

### tb/testbench.sv
// Self-checking testbench of the S-curve speed profile planner with a built-in behavioral predictor.
module testbench;

  import scsp_pkg::*;

  localparam int          NUM_SEGS       = 6;
  localparam logic [11:0] OFF_MID        = 12'd60;
  localparam logic [11:0] OFF_HIGH       = 12'd120;
  localparam logic [15:0] STOP_SPEED     = 16'd384;
  localparam int          HOLD_TICKS     = 5;
  localparam int          SETTLE_CYCLES  = 60;    // Well above the longest run tick.
  localparam int          WATCHDOG_LIMIT = 3000;  // Cycles in a row without any handshake.

  // Register contents after reset, one entry per table segment.
  localparam logic [47:0] SEG_DEFAULT [NUM_SEGS] = '{
    48'd1090519190, 48'd2148574167040, 48'd4295772602488,
    48'd6443256250368, 48'd9020521840760, 48'd12026998947840
  };

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_EXIT  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_RUN    = 2'd1,
    PH_FINISH = 2'd2,
    PH_STOP   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    DAMP_LOW  = 2'd0,
    DAMP_MID  = 2'd1,
    DAMP_HIGH = 2'd2,
    DAMP_HOLD = 2'd3
  } damping_e;

  typedef enum logic [2:0] {
    REG_SEG0      = 3'd0,
    REG_SEG1      = 3'd1,
    REG_SEG2      = 3'd2,
    REG_SEG3      = 3'd3,
    REG_SEG4      = 3'd4,
    REG_SEG5      = 3'd5,
    REG_FIN_YAW   = 3'd6,
    REG_STOP_RAMP = 3'd7
  } reg_e;

  // One control event as it travels on the input channel.
  typedef struct packed {
    action_e     act;
    logic [15:0] yaw;
    logic        fin;
    logic [11:0] off;
  } cmd_t;

  // One result item; the member order mirrors the result tdata layout from the top bit down.
  typedef struct packed {
    logic [31:0] ftime;
    logic        stopm;
    logic        clr;
    logic        track;
    logic [1:0]  damp;
    logic [2:0]  seg;
    logic [1:0]  phase;
    logic [15:0] speed;
  } status_t;

  // Clock, reset and block inputs, all known from time zero.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic [2:0]  cfg_index_i   = '0;
  logic [47:0] cfg_data_i    = '0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [63:0] m_axis_tdata;
  logic        cfg_ready_o;

  always #6 clk_i = ~clk_i;

  s_curve_speed_profile_planner u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  wire s_fire   = s_axis_tvalid && s_axis_tready;
  wire m_fire   = m_axis_tvalid && m_axis_tready;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  cmd_t        cmd_backlog [$];   // Items waiting for the input driver.
  status_t     status_due  [$];   // Predicted results in the order they must come out.
  logic [47:0] reg_plan [8];      // Register values for the next configuration pass.
  int          queued_items = 0;
  int          bad_fields   = 0;
  int          still_cycles = 0;
  int          send_gap     = 0;
  int          sink_gap     = 0;
  bit          steady_flow  = 1'b0;  // Set for the last part of the run: no idling at all.
  cmd_t        next_cmd, arrived_cmd;
  status_t     due_status, seen_status;

  // Predictor copy of the registers and of the sequencer state.
  logic [47:0] seg_tab [NUM_SEGS];
  logic [15:0] fin_yaw, stop_len;
  phase_e      phase_now;
  logic [2:0]  seg_now;
  curve_t      ramp;
  logic [2:0]  hold_left;
  logic [11:0] off_before;
  logic [31:0] tick_count, finish_stamp;
  logic [15:0] speed_now;

  function automatic logic [15:0] tab_yaw(int i);
    return seg_tab[i][47:32];
  endfunction

  function automatic logic [15:0] tab_speed(int i);
    return seg_tab[i][31:16];
  endfunction

  function automatic logic [15:0] tab_ramp(int i);
    return seg_tab[i][15:0];
  endfunction

  function automatic void start_ramp(logic [15:0] from, logic [15:0] to, logic [15:0] len);
    ramp.origin = from;
    ramp.target = to;
    ramp.length = len;
    ramp.pos    = '0;
  endfunction

  // Smoothstep 3t^2 - 2t^3 in Q16, applied to the speed difference with rounding.
  function automatic logic [15:0] ramp_point(curve_t c);
    logic [63:0] tq, t2, s, mag, step;
    if (c.length == 0 || c.pos >= c.length) return c.target;
    tq = ({48'd0, c.pos} << 16) / {48'd0, c.length};
    t2 = (tq * tq) >> 16;
    s  = (t2 * (64'd196608 - (tq << 1))) >> 16;
    if (c.target >= c.origin) begin
      mag  = {48'd0, c.target} - {48'd0, c.origin};
      step = (mag * s + 64'd32768) >> 16;
      return 16'({48'd0, c.origin} + step);
    end
    mag  = {48'd0, c.origin} - {48'd0, c.target};
    step = (mag * s + 64'd32768) >> 16;
    return 16'({48'd0, c.origin} - step);
  endfunction

  function automatic logic [15:0] ramp_step();
    if (ramp.length == 0) return ramp.target;
    if (ramp.pos < ramp.length) ramp.pos = ramp.pos + 16'd1;
    return ramp_point(ramp);
  endfunction

  // Tracking stays off while the post-finish hold is counting down.
  function automatic logic gate_tracking();
    if (hold_left == 0) return 1'b1;
    hold_left = hold_left - 3'd1;
    return 1'b0;
  endfunction

  function automatic damping_e damping_for(logic [11:0] off);
    if (off > OFF_HIGH) return DAMP_HIGH;
    if (off > OFF_MID) return DAMP_MID;
    return DAMP_LOW;
  endfunction

  function automatic void reset_model();
    int i;
    for (i = 0; i < NUM_SEGS; i++) seg_tab[i] = SEG_DEFAULT[i];
    fin_yaw      = 16'd3200;
    stop_len     = 16'd250;
    phase_now    = PH_IDLE;
    seg_now      = '0;
    start_ramp(16'd0, tab_speed(0), tab_ramp(0));
    hold_left    = '0;
    off_before   = '0;
    tick_count   = '0;
    finish_stamp = '0;
    speed_now    = '0;
  endfunction

  function automatic void apply_reg(reg_e idx, logic [47:0] value);
    case (idx)
      REG_FIN_YAW:   fin_yaw = value[15:0];
      REG_STOP_RAMP: stop_len = value[15:0];
      default:       seg_tab[idx] = value;
    endcase
  endfunction

  // Advances the predictor by one control event and returns the result it must produce.
  function automatic status_t predict_status(cmd_t c);
    status_t    r;
    logic [2:0] idx;
    logic [15:0] cur;
    bit         walking;
    int         i;
    r       = '0;
    r.damp  = DAMP_HOLD;
    case (c.act)
      ACT_START: begin
        // A start key only counts in idle; hold and offset history survive it.
        if (phase_now == PH_IDLE) begin
          phase_now  = PH_RUN;
          tick_count = '0;
          seg_now    = '0;
          start_ramp(16'd0, tab_speed(0), tab_ramp(0));
          speed_now  = '0;
        end
      end
      ACT_EXIT: begin
        phase_now = PH_IDLE;
        speed_now = '0;
        r.stopm   = 1'b1;
      end
      ACT_TICK: begin
        if (phase_now == PH_RUN) begin
          // The segment walk only moves forward and stops at the first entry not yet reached.
          idx     = seg_now;
          walking = 1'b1;
          for (i = 1; i < NUM_SEGS; i++) begin
            if (walking && i > idx) begin
              if (c.yaw >= tab_yaw(i)) idx = 3'(i);
              else walking = 1'b0;
            end
          end
          if (idx != seg_now) begin
            start_ramp(ramp_point(ramp), tab_speed(idx), tab_ramp(idx));
            seg_now = idx;
          end
          speed_now = ramp_step();
          if (tick_count != '1) tick_count = tick_count + 32'd1;
          r.track    = gate_tracking();
          r.damp     = damping_for(c.off);
          r.clr      = (off_before > OFF_MID) && (c.off <= OFF_MID);
          off_before = c.off;
          if (c.yaw > fin_yaw && c.fin) begin
            phase_now    = PH_FINISH;
            finish_stamp = tick_count;
            hold_left    = 3'(HOLD_TICKS);
            start_ramp(ramp_point(ramp), 16'd0, stop_len);
          end
        end else if (phase_now == PH_FINISH) begin
          cur       = ramp_step();
          speed_now = cur;
          r.track   = gate_tracking();
          r.damp    = damping_for(c.off);
          if (cur < STOP_SPEED) begin
            phase_now = PH_STOP;
            speed_now = '0;
            r.stopm   = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.speed = speed_now;
    r.phase = phase_now;
    r.seg   = seg_now;
    r.ftime = finish_stamp;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      bad_fields++;
    end
  endfunction

  // Input driver: presents backlog items one by one, with occasional idle bursts after an item.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (cmd_backlog.size() != 0) begin
        next_cmd = cmd_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, next_cmd.off, next_cmd.fin, next_cmd.yaw};
        s_axis_tuser  <= next_cmd.act;
        if (!steady_flow && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 17);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: ready most of the time, with random stall bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap      <= 0;
    end else if (sink_gap != 0) begin
      m_axis_tready <= 1'b0;
      sink_gap      <= sink_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady_flow && $urandom_range(0, 9) == 0) sink_gap <= $urandom_range(1, 17);
    end
  end

  // Monitor: follows register writes, predicts each accepted item and checks each result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_fire) apply_reg(reg_e'(cfg_index_i), cfg_data_i);
      // The result is checked before this edge's input is predicted, since it cannot
      // belong to an item accepted at the same edge.
      if (m_fire) begin
        seen_status = status_t'(m_axis_tdata[57:0]);
        if (status_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          bad_fields++;
        end else begin
          due_status = status_due.pop_front();
          check_field("speed_command", 32'(due_status.speed), 32'(seen_status.speed));
          check_field("phase", 32'(due_status.phase), 32'(seen_status.phase));
          check_field("segment_index", 32'(due_status.seg), 32'(seen_status.seg));
          check_field("damping_level", 32'(due_status.damp), 32'(seen_status.damp));
          check_field("run_tracking", 32'(due_status.track), 32'(seen_status.track));
          check_field("clear_integral", 32'(due_status.clr), 32'(seen_status.clr));
          check_field("stop_motors", 32'(due_status.stopm), 32'(seen_status.stopm));
          check_field("finish_time", due_status.ftime, seen_status.ftime);
        end
      end
      if (s_fire) begin
        arrived_cmd.act = action_e'(s_axis_tuser);
        arrived_cmd.yaw = s_axis_tdata[15:0];
        arrived_cmd.fin = s_axis_tdata[16];
        arrived_cmd.off = s_axis_tdata[28:17];
        status_due.push_back(predict_status(arrived_cmd));
      end
    end
  end

  // Watchdog: a block that stops trading items for too long has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || s_fire || m_fire || cfg_fire) still_cycles <= 0;
    else still_cycles <= still_cycles + 1;
    if (still_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_cmd(action_e a, int y, bit f, int o);
    cmd_t c;
    c.act = a;
    c.yaw = 16'(y);
    c.fin = f;
    c.off = 12'(o);
    cmd_backlog.push_back(c);
    queued_items++;
  endtask

  // Offsets cluster around the damping thresholds, with some spread over the full range.
  function automatic int rand_offset();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 60);
      1:       return $urandom_range(55, 130);
      2:       return $urandom_range(0, 4095);
      default: return $urandom_range(118, 123);
    endcase
  endfunction

  // Writes all eight registers from reg_plan, back to back.
  task automatic program_regs();
    int i;
    @(posedge clk_i);
    for (i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i  <= reg_plan[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every item is in and every result is out, then lets the block settle.
  task automatic drain();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || s_axis_tvalid || status_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // A table with mostly rising start yaws, short ramps and now and then an odd entry.
  task automatic random_table();
    int i, y, yv, spd, len;
    y = $urandom_range(0, 400);
    for (i = 0; i < NUM_SEGS; i++) begin
      yv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : y;
      y  = y + $urandom_range(0, 2500);
      if (y > 65535) y = 65535;
      case ($urandom_range(0, 7))
        0:       spd = 0;
        1:       spd = 65535;
        default: spd = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 7))
        0:       len = 0;
        1:       len = $urandom_range(0, 65535);
        default: len = $urandom_range(1, 25);
      endcase
      reg_plan[i] = {16'(yv), 16'(spd), 16'(len)};
    end
    reg_plan[REG_FIN_YAW]   = 48'($urandom_range(0, y));
    reg_plan[REG_STOP_RAMP] = 48'($urandom_range(0, 30));
  endtask

  // A start, a run of ticks with climbing yaw, a tail of ticks more often flagged as finished, then mostly an exit.
  task automatic queue_run();
    int y, steps, k;
    push_cmd(ACT_START, $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
             $urandom_range(0, 4095));
    y     = $urandom_range(0, 300);
    steps = $urandom_range(3, 60);
    for (k = 0; k < steps; k++) begin
      y = y + $urandom_range(0, 500);
      if (y > 65535) y = 65535;
      push_cmd(ACT_TICK, y, $urandom_range(0, 5) == 0, rand_offset());
    end
    steps = $urandom_range(0, 36);
    for (k = 0; k < steps; k++) begin
      y = y + $urandom_range(0, 200);
      if (y > 65535) y = 65535;
      push_cmd(ACT_TICK, y, $urandom_range(0, 2) == 0, rand_offset());
    end
    if ($urandom_range(0, 7) != 0)
      push_cmd(ACT_EXIT, $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
               $urandom_range(0, 4095));
  endtask

  // Mostly well-formed runs, the rest single items of any kind with any field values.
  task automatic random_phase(int budget);
    int goal;
    goal = queued_items + budget;
    while (queued_items < goal) begin
      if ($urandom_range(0, 6) == 0)
        push_cmd(action_e'($urandom_range(0, 3)), $urandom_range(0, 65535),
                 1'($urandom_range(0, 1)), $urandom_range(0, 4095));
      else
        queue_run();
    end
  endtask

  initial begin
    int i;
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the default table with a short stop ramp. Default yaw breakpoints
    // are 0, 500, 1000, 1500, 2100 and 2800, and the finish threshold is 3200.
    for (i = 0; i < NUM_SEGS; i++) reg_plan[i] = SEG_DEFAULT[i];
    reg_plan[REG_FIN_YAW]   = 48'd3200;
    reg_plan[REG_STOP_RAMP] = 48'd4;
    program_regs();
    push_cmd(ACT_TICK, 65535, 1'b1, 4095);   // Tick in idle does nothing.
    push_cmd(ACT_NONE, 0, 1'b0, 0);          // Unused action only shows the held state.
    push_cmd(ACT_START, 0, 1'b0, 0);
    push_cmd(ACT_START, 65535, 1'b1, 4095);  // A second start during run is ignored.
    push_cmd(ACT_TICK, 0, 1'b0, 0);
    push_cmd(ACT_TICK, 100, 1'b0, 61);       // Mid damping.
    push_cmd(ACT_TICK, 520, 1'b0, 121);      // High damping, second segment.
    push_cmd(ACT_TICK, 600, 1'b0, 120);
    push_cmd(ACT_TICK, 700, 1'b0, 60);       // Offset falls back inside 60: integral clear.
    push_cmd(ACT_TICK, 2900, 1'b0, 0);       // Walks several segments at once.
    push_cmd(ACT_TICK, 3200, 1'b1, 4095);    // Finish seen, but yaw is not past the threshold.
    push_cmd(ACT_EXIT, 3200, 1'b0, 0);       // Exit from run.
    push_cmd(ACT_START, 0, 1'b0, 0);
    push_cmd(ACT_TICK, 65535, 1'b0, 2048);
    push_cmd(ACT_TICK, 65535, 1'b1, 100);    // Finish confirmed: latch time, ramp to zero.
    for (i = 0; i < 6; i++) push_cmd(ACT_TICK, 65535, 1'b0, 4095 - i * 800);
    push_cmd(ACT_TICK, 65535, 1'b1, 0);      // Tick in stopped does nothing.
    push_cmd(ACT_START, 0, 1'b0, 0);         // Start outside idle is ignored.
    push_cmd(ACT_EXIT, 65535, 1'b1, 4095);   // Exit from stopped.
    drain();

    // Random tables with idling on both sides.
    repeat (3) begin
      random_table();
      program_regs();
      random_phase(300);
      drain();
    end

    // All registers cleared: every tick jumps to the last segment and the stop is immediate.
    for (i = 0; i < 8; i++) reg_plan[i] = '0;
    program_regs();
    random_phase(130);
    drain();

    // All registers at their maximum: finish can never be confirmed and ramps are very long.
    for (i = 0; i < 8; i++) reg_plan[i] = '1;
    program_regs();
    random_phase(130);
    drain();

    // Last part at full throughput.
    steady_flow = 1'b1;
    random_table();
    program_regs();
    random_phase(300);
    drain();

    if (bad_fields == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### s_curve_speed_profile_planner.f
rtl/scsp_pkg.sv
rtl/scsp_curve_eval.sv
rtl/s_curve_speed_profile_planner.sv
tb/testbench.sv
